// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/acbc_pkg.sv =====
// Package: AES tables, round functions and register codes.
`timescale 1ns / 1ps
package acbc_pkg;

  typedef logic [7:0] sbox_t [256];
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_KEY_HIGH = 2'd0;
  localparam reg_idx_t REG_KEY_LOW  = 2'd1;
  localparam reg_idx_t REG_IV_HIGH  = 2'd2;
  localparam reg_idx_t REG_IV_LOW   = 2'd3;

  localparam int NUM_STAGES = 20;

  localparam sbox_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_t build_inv_sbox();
    sbox_t inv;
    for (int i = 0; i < 256; i++) begin
      inv[SBOX[i]] = 8'(i);
    end
    return inv;
  endfunction

  localparam sbox_t INV_SBOX = build_inv_sbox();

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // g() of the key schedule: rotate, substitute, add round constant
  function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
    logic [31:0] r;
    r = {w[23:0], w[31:24]};
    return {SBOX[r[31:24]] ^ rc, SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ key_g(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_g(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

  // byte n at bits [127-8n -: 8]; row n%4, column n/4
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] x);
    logic [127:0] y;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        y[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[x[127 - 8 * (r + 4 * ((c - r + 4) & 3)) -: 8]];
      end
    end
    return y;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] x);
    logic [127:0] y;
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = x[127 - 8 * (4 * c + r) -: 8];
        x2 = xt(a[r]);
        x4 = xt(x2);
        x8 = xt(x4);
        m9[r] = x8 ^ a[r];
        m11[r] = x8 ^ x2 ^ a[r];
        m13[r] = x8 ^ x4 ^ a[r];
        m14[r] = x8 ^ x4 ^ x2;
      end
      y[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      y[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      y[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      y[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return y;
  endfunction

endpackage

// ===== hdl/acbc_ifs.sv =====
// Interfaces: ciphertext input channel and plaintext output channel.
`timescale 1ns / 1ps
interface acbc_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        first_block;
  modport source (output valid, cipher_high, cipher_low, first_block, input ready);
  modport sink (input valid, cipher_high, cipher_low, first_block, output ready);
endinterface

interface acbc_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

// ===== hdl/aes128_cbc_decryptor_top.sv =====
// Top level: AES-128 CBC decryptor, 20-stage pipeline with APB register port.
//
// Usage:
//   cipher channel takes one ciphertext word per cycle (two 64-bit halves,
//   byte 0 most significant, plus first_block to restart the chain from IV).
//   plain channel delivers one plaintext word per ciphertext word, in order.
//   Registers key_high/key_low/iv_high/iv_low at APB byte addresses 0/8/16/24,
//   which the user writes only while idle (not enforced); a new key applies to the next word.
// Stages: ten stages expand the key forward to round 10, ten stages run the
//   inverse rounds while walking the schedule back down; each word carries its
//   own 128-bit round key.
// Throughput: one word per cycle while the pipeline is not stalled.
// Stall: when plain.ready is low with a word on the output, the whole
//   pipeline holds and cipher.ready drops; nothing is lost or repeated.
// Reset: rst (synchronous) clears all stage valid bits, the registers and
//   the previous-ciphertext chain value.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes128_cbc_decryptor_top (
  input  logic        clk,
  input  logic        rst,
  acbc_cipher_if.sink cipher,
  acbc_plain_if.source plain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import acbc_pkg::*;

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [127:0] prev_cipher;
  reg_idx_t    reg_idx;
  logic        cfg_wr;
  logic        en;
  logic        accept;

  logic         v     [NUM_STAGES];
  logic [127:0] st    [NUM_STAGES];
  logic [127:0] key   [NUM_STAGES];
  logic [127:0] chain [NUM_STAGES];
  logic         v_next     [NUM_STAGES];
  logic [127:0] st_next    [NUM_STAGES];
  logic [127:0] key_next   [NUM_STAGES];
  logic [127:0] chain_next [NUM_STAGES];

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_IV_HIGH:  iv_high  <= pwdata;
        REG_IV_LOW:   iv_low   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_IV_HIGH:  prdata = iv_high;
      REG_IV_LOW:   prdata = iv_low;
      default:      prdata = '0;
    endcase
  end

  assign en           = !v[NUM_STAGES-1] || plain.ready;
  assign cipher.ready = en;
  assign accept       = cipher.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cipher <= '0;
    end else if (accept) begin
      prev_cipher <= {cipher.cipher_high, cipher.cipher_low};
    end
  end

  genvar i;
  generate
    for (i = 0; i < NUM_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_entry
        assign v_next[i]     = cipher.valid;
        assign st_next[i]    = {cipher.cipher_high, cipher.cipher_low};
        assign key_next[i]   = key_fwd({key_high, key_low}, RCON[0]);
        assign chain_next[i] = cipher.first_block ? {iv_high, iv_low} : prev_cipher;
      end else if (i < 9) begin : g_expand
        assign v_next[i]     = v[i-1];
        assign st_next[i]    = st[i-1];
        assign key_next[i]   = key_fwd(key[i-1], RCON[i]);
        assign chain_next[i] = chain[i-1];
      end else if (i == 9) begin : g_first_add
        assign v_next[i]     = v[i-1];
        assign key_next[i]   = key_fwd(key[i-1], RCON[i]);
        assign st_next[i]    = st[i-1] ^ key_next[i];
        assign chain_next[i] = chain[i-1];
      end else if (i < NUM_STAGES - 1) begin : g_round
        localparam int R = NUM_STAGES - 1 - i;
        assign v_next[i]     = v[i-1];
        assign key_next[i]   = key_bwd(key[i-1], RCON[R]);
        assign st_next[i]    = inv_mix(inv_shift_sub(st[i-1]) ^ key_next[i]);
        assign chain_next[i] = chain[i-1];
      end else begin : g_last
        assign v_next[i]     = v[i-1];
        assign key_next[i]   = key_bwd(key[i-1], RCON[0]);
        assign st_next[i]    = inv_shift_sub(st[i-1]) ^ key_next[i] ^ chain[i-1];
        assign chain_next[i] = chain[i-1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en) begin
          v[i] <= v_next[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st[i]    <= st_next[i];
          key[i]   <= key_next[i];
          chain[i] <= chain_next[i];
        end
      end
    end
  endgenerate

  assign plain.valid      = v[NUM_STAGES-1];
  assign plain.plain_high = st[NUM_STAGES-1][127:64];
  assign plain.plain_low  = st[NUM_STAGES-1][63:0];

  `AST_IMP(a_stall_only_when_full, clk, rst, !cipher.ready, plain.valid)
  `AST_NEXT(a_accept_enters, clk, rst, accept, v[0])
  `AST_NEXT(a_mid_advance, clk, rst, en && v[9], v[10])
  `AST_NEXT(a_hold_on_stall, clk, rst, !en, $stable(st[NUM_STAGES-1]) && plain.valid)

endmodule
